@@ sv/b64d_pkg.sv @@
// Shared types, constants and the character decode function for the Base64 decoder.
// No dependencies; every other file in this folder imports this package.
package b64d_pkg;

  localparam int COUNT_BITS = 24;
  localparam int CAP_BITS   = 24;
  localparam int CFG_W      = CAP_BITS;
  localparam int CFG_IDX_W  = 1;
  localparam int CMP_W      = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

  // result queue geometry; a single item causes at most Q_ROOM results
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;
  localparam int Q_ROOM = 3;

  localparam logic [7:0] CODE_BAD = 8'h80;
  localparam logic [7:0] CODE_PAD = 8'hC0;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRICT   = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0]            out_byte;
    logic                  is_status;
    status_t               status;
    logic [COUNT_BITS-1:0] byte_count;
    logic                  last;
  } out_t;

  typedef struct packed {
    logic                strict_mode;
    logic [CAP_BITS-1:0] out_capacity;
  } cfg_t;

  // results made by one accepted item, written to the queue together
  typedef struct packed {
    logic [1:0] n;
    out_t [2:0] res;
  } push_t;

  function automatic logic [7:0] char_code(input logic [7:0] c);
    logic [7:0] code;
    code = CODE_BAD;
    if (c >= 8'h41 && c <= 8'h5A) begin
      code = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      code = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      code = c + 8'd4;
    end else if (c == 8'h2B) begin
      code = 8'd62;
    end else if (c == 8'h2F) begin
      code = 8'd63;
    end else if (c == 8'h3D) begin
      code = CODE_PAD;
    end
    return code;
  endfunction

endpackage

@@ sv/b64d_core.sv @@
// Stream state of the decoder: quartet gathering, byte assembly, capacity check, status.
// Depends on b64d_pkg; feeds the result queue through a push_t group.
module b64d_core (
  input  logic           clk,
  input  logic           rst,
  input  b64d_pkg::cfg_t cfg,
  input  logic           fire,
  input  b64d_pkg::in_t  item,
  output b64d_pkg::push_t push
);
  import b64d_pkg::*;

  logic [7:0]            codes [3];
  logic [1:0]            fill;
  logic [COUNT_BITS-1:0] written;
  logic                  overflow;
  logic                  invalid;

  logic [7:0]     code;
  logic [7:0]     d0, d1, d2, d3;
  logic [7:0]     b0, b1, b2;
  logic [1:0]     grp_n;
  logic [CMP_W-1:0] sum;
  logic           fits;
  logic           is_bad;
  logic           quartet_done;
  status_t        end_status;

  always_comb begin
    code = char_code(item.in_char);
    d0 = codes[0];
    d1 = codes[1];
    d2 = codes[2];
    d3 = code;
    // pad codes enter the arithmetic unchanged, kept to 8 bits
    b0 = (d0 << 2) | (d1 >> 4);
    b1 = ((d1 & 8'h0F) << 4) | (d2 >> 2);
    b2 = ((d2 & 8'h03) << 6) | d3;
    grp_n = 2'd1 + {1'b0, d2 != CODE_PAD} + {1'b0, d3 != CODE_PAD};
    sum   = CMP_W'(written) + CMP_W'(grp_n);
    fits  = sum <= CMP_W'(cfg.out_capacity);
    is_bad = (code == CODE_BAD);
    quartet_done = !item.end_of_text && !invalid && !is_bad && (fill == 2'd3);

    if (invalid) begin
      end_status = ST_INVALID;
    end else if (overflow) begin
      end_status = ST_OVERFLOW;
    end else if (fill != 2'd0) begin
      end_status = ST_INCOMPLETE;
    end else begin
      end_status = ST_OK;
    end

    push = '0;
    if (fire && item.end_of_text) begin
      push.n                   = 2'd1;
      push.res[0].is_status    = 1'b1;
      push.res[0].status       = end_status;
      push.res[0].byte_count   = (end_status == ST_OK) ? written : '0;
      push.res[0].last         = 1'b1;
    end else if (fire && quartet_done && fits) begin
      push.n = grp_n;
      push.res[0].out_byte = b0;
      // third code pad but fourth not: second byte sent is the third byte
      push.res[1].out_byte = (d2 != CODE_PAD) ? b1 : b2;
      push.res[2].out_byte = b2;
      for (int i = 0; i < 3; i++) begin
        push.res[i].last = (2'(i) == grp_n - 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      written  <= '0;
      overflow <= 1'b0;
      invalid  <= 1'b0;
    end else if (fire) begin
      if (item.end_of_text) begin
        fill     <= '0;
        written  <= '0;
        overflow <= 1'b0;
        invalid  <= 1'b0;
      end else if (!invalid) begin
        if (is_bad) begin
          if (cfg.strict_mode) begin
            invalid <= 1'b1;
          end
        end else if (fill != 2'd3) begin
          fill <= fill + 2'd1;
        end else begin
          fill <= '0;
          if (fits) begin
            written <= sum[COUNT_BITS-1:0];
          end else begin
            overflow <= 1'b1;
          end
        end
      end
    end
  end

  // code store needs no reset: an entry is read only after it is written
  always_ff @(posedge clk) begin
    if (fire && !item.end_of_text && !invalid && !is_bad && fill != 2'd3) begin
      codes[fill] <= code;
    end
  end

  a_eot_single : assert property (@(posedge clk) disable iff (rst)
    (fire && item.end_of_text) |-> (push.n == 2'd1 && push.res[0].is_status))
    else $error("end of text must give exactly one status result");

  a_eot_clears : assert property (@(posedge clk) disable iff (rst)
    (fire && item.end_of_text) |=> (fill == 2'd0 && written == '0 && !overflow && !invalid))
    else $error("stream state not cleared after end of text");

  a_group_last : assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> push.res[push.n - 2'd1].last)
    else $error("final result of a group lacks last");

  a_invalid_silent : assert property (@(posedge clk) disable iff (rst)
    (fire && invalid && !item.end_of_text) |-> (push.n == 2'd0))
    else $error("characters after a strict error produced results");

endmodule

@@ sv/b64d_queue.sv @@
// Result queue: takes up to three results per cycle, hands out one per cycle while res_stall is low.
// Depends on b64d_pkg; flags full while fewer than three slots are free.
module b64d_queue (
  input  logic            clk,
  input  logic            rst,
  input  b64d_pkg::push_t push,
  output logic            full,
  output logic            res_valid,
  input  logic            res_stall,
  output b64d_pkg::out_t  res_data
);
  import b64d_pkg::*;

  out_t           slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           pop;

  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != '0);
  assign res_data  = slots[rd_ptr];
  assign full      = count > QCW'(QDEPTH - Q_ROOM);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(push.n);
      rd_ptr <= rd_ptr + QAW'(pop);
      count  <= count + QCW'(push.n) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_ROOM; i++) begin
      if (2'(i) < push.n) begin
        slots[wr_ptr + QAW'(i)] <= push.res[i];
      end
    end
  end

  a_no_overfill : assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("result queue count beyond depth");

  a_push_has_room : assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (count <= QCW'(QDEPTH - Q_ROOM)))
    else $error("results pushed without room for a full group");

  a_count_track : assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd0 && pop) |=> (count == $past(count) - QCW'(1)))
    else $error("queue count lost track of a drained result");

endmodule

@@ sv/base64_stream_decoder.sv @@
// Base64 stream decoder, one text character per transfer, decoded bytes and status out.
// Results of an accepted character are in the result queue from the cycle after its transfer.
// Throughput: one character per cycle; results leave an 8-entry queue one per cycle while
// res_stall is low; the character side stalls while fewer than three queue slots are free.
// Reset (rst, synchronous): clears stream state and queue; strict_mode 0, capacity all ones.
module base64_stream_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  b64d_pkg::in_t                   char_data,
  output logic                            res_valid,
  input  logic                            res_stall,
  output b64d_pkg::out_t                  res_data,
  input  logic                            cfg_we,
  input  logic [b64d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [b64d_pkg::CFG_W-1:0]      cfg_data
);
  import b64d_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  fire;
  logic  full;

  assign char_stall = full;
  assign fire       = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strict_mode  <= 1'b0;
      cfg.out_capacity <= '1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_STRICT:   cfg.strict_mode  <= cfg_data[0];
        REG_CAPACITY: cfg.out_capacity <= cfg_data[CAP_BITS-1:0];
        default:      cfg.strict_mode  <= cfg.strict_mode;
      endcase
    end
  end

  b64d_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (char_data),
    .push (push)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

@@ tb/b64d_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the Base64 stream decoder: watches the character, result and register ports,
// decodes accepted characters on its own and compares every result transfer. Needs b64d_pkg.
module b64d_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           char_valid,
  input  logic                           char_stall,
  input  b64d_pkg::in_t                  char_data,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  b64d_pkg::out_t                 res_data,
  input  logic                           cfg_we,
  input  logic [b64d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [b64d_pkg::CFG_W-1:0]     cfg_data,
  output int                             outstanding,
  output int                             fail_count
);
  import b64d_pkg::*;

  logic                  strict_q;
  logic [CAP_BITS-1:0]   cap_q;
  logic [7:0]            codes [3];
  logic [1:0]            fill;
  logic [COUNT_BITS-1:0] bytes_sent;
  logic                  ovf_seen;
  logic                  bad_seen;
  out_t                  decoded_q [$];

  function automatic logic [7:0] sextet(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      return 8'd62;
    end else if (c == 8'h2F) begin
      return 8'd63;
    end else if (c == 8'h3D) begin
      return CODE_PAD;
    end
    return CODE_BAD;
  endfunction

  task automatic report(input string msg);
    if (fail_count < 50) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic decode_item(input in_t it);
    out_t        r;
    logic [7:0]  code;
    logic [7:0]  grp [3];
    logic [31:0] d0, d1, d2, d3;
    int          n;
    r = '0;
    n = 0;
    if (it.end_of_text) begin
      r.is_status = 1'b1;
      r.last      = 1'b1;
      if (bad_seen) begin
        r.status = ST_INVALID;
      end else if (ovf_seen) begin
        r.status = ST_OVERFLOW;
      end else if (fill != 2'd0) begin
        r.status = ST_INCOMPLETE;
      end else begin
        r.status     = ST_OK;
        r.byte_count = bytes_sent;
      end
      decoded_q.push_back(r);
      fill       = 2'd0;
      bytes_sent = '0;
      ovf_seen   = 1'b0;
      bad_seen   = 1'b0;
    end else if (!bad_seen) begin
      code = sextet(it.in_char);
      if (code == CODE_BAD) begin
        if (strict_q) bad_seen = 1'b1;
      end else if (fill != 2'd3) begin
        codes[fill] = code;
        fill        = fill + 2'd1;
      end else begin
        // pad codes go into the shifts as they are; keep 8 bits
        d0 = {24'd0, codes[0]};
        d1 = {24'd0, codes[1]};
        d2 = {24'd0, codes[2]};
        d3 = {24'd0, code};
        grp[n] = 8'((d0 << 2) | (d1 >> 4));
        n++;
        if (codes[2] != CODE_PAD) begin
          grp[n] = 8'(((d1 & 32'h0F) << 4) | (d2 >> 2));
          n++;
        end
        if (code != CODE_PAD) begin
          grp[n] = 8'(((d2 & 32'h03) << 6) | d3);
          n++;
        end
        fill = 2'd0;
        if (int'(bytes_sent) + n <= int'(cap_q)) begin
          for (int i = 0; i < n; i++) begin
            r          = '0;
            r.out_byte = grp[i];
            r.last     = (i == n - 1);
            decoded_q.push_back(r);
          end
          bytes_sent = bytes_sent + COUNT_BITS'(n);
        end else begin
          ovf_seen = 1'b1;
        end
      end
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (decoded_q.size() == 0) begin
      report($sformatf("result %h with nothing expected", got));
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
    if (got.is_status !== want.is_status)
      report($sformatf("is_status %b, expected %b", got.is_status, want.is_status));
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.byte_count !== want.byte_count)
      report($sformatf("byte_count %0d, expected %0d", got.byte_count, want.byte_count));
    if (got.last !== want.last)
      report($sformatf("last %b, expected %b", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      strict_q   = 1'b0;
      cap_q      = '1;
      codes[0]   = '0;
      codes[1]   = '0;
      codes[2]   = '0;
      fill       = 2'd0;
      bytes_sent = '0;
      ovf_seen   = 1'b0;
      bad_seen   = 1'b0;
      fail_count = 0;
      decoded_q.delete();
    end else begin
      if (res_valid && !res_stall) check_result(res_data);
      if (char_valid && !char_stall) decode_item(char_data);
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_STRICT:   strict_q = cfg_data[0];
          REG_CAPACITY: cap_q    = cfg_data[CAP_BITS-1:0];
          default: ;
        endcase
      end
    end
    outstanding <= decoded_q.size();
  end

endmodule

@@ tb/tb_base64_stream_decoder.sv @@
`timescale 1ns / 1ps
// Top of the Base64 stream decoder testbench: clock, reset, character and register stimulus,
// receiver stalls and the verdict. Needs b64d_pkg, the decoder and b64d_checker.
module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam int              QUIET_LIMIT = 3000;
  localparam int              HOLD_CYCLES = 240;
  localparam logic [CFG_W-1:0] CAP_MAX    = '1;
  localparam logic [7:0]      PAD_CHAR    = 8'h3D;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 char_valid = 1'b0;
  logic                 char_stall;
  in_t                  char_data  = '0;
  logic                 res_valid;
  logic                 res_stall  = 1'b0;
  out_t                 res_data;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  int outstanding;
  int fail_count;
  int sent_count = 0;
  int quiet      = 0;
  bit tx_gaps    = 1'b0;
  bit rx_gaps    = 1'b0;
  bit hold_off   = 1'b0;

  always #5 clk = ~clk;

  base64_stream_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  b64d_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_data   (char_data),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_data    (res_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  function automatic logic [7:0] sextet_char(input int v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // returns right after the edge that took the transfer
  task automatic send_item(input in_t it);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= it;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_char(input logic [7:0] c);
    in_t it;
    it.in_char     = c;
    it.end_of_text = 1'b0;
    send_item(it);
  endtask

  task automatic send_eot();
    in_t it;
    it.in_char     = 8'($urandom_range(0, 255));
    it.end_of_text = 1'b1;
    send_item(it);
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // well-formed quartets with random content, sometimes padded, cut short or salted with junk
  task automatic send_text();
    logic [7:0] txt [$];
    int         nq;
    int         pad_kind;
    bit         noisy;
    nq = $urandom_range(0, 5);
    for (int q = 0; q < 4 * nq; q++) txt.push_back(sextet_char($urandom_range(0, 63)));
    if (nq > 0) begin
      pad_kind = $urandom_range(0, 9);
      if (pad_kind == 6) begin
        txt[txt.size()-1] = PAD_CHAR;
      end else if (pad_kind == 7) begin
        txt[txt.size()-1] = PAD_CHAR;
        txt[txt.size()-2] = PAD_CHAR;
      end else if (pad_kind >= 8) begin
        for (int k = 1; k <= 4; k++) begin
          if ($urandom_range(0, 2) == 0) txt[txt.size()-k] = PAD_CHAR;
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) txt.delete(txt.size() - 1);
      end
    end
    noisy = ($urandom_range(0, 9) < 3);
    if (noisy && txt.size() == 0) send_char(8'($urandom_range(0, 255)));
    for (int i = 0; i < txt.size(); i++) begin
      if (noisy && $urandom_range(0, 5) == 0) send_char(8'($urandom_range(0, 255)));
      send_char(txt[i]);
    end
    if ($urandom_range(0, 9) != 0) send_eot();
  endtask

  // hold the sender until every result is out, then let trailing work settle
  task automatic drain();
    char_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    bit               strict_sel;
    logic [CFG_W-1:0] cap_sel;
    int               phase_start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_STRICT, CFG_W'(0));
    write_reg(REG_CAPACITY, CAP_MAX);
    send_chars("////");
    send_chars("==A=");
    send_chars("QQ=B");
    send_char(8'hFF);
    send_char(8'h00);
    send_eot();
    drain();

    // fill to capacity, overflow, then a strict error that outranks it
    write_reg(REG_STRICT, CFG_W'(1));
    write_reg(REG_CAPACITY, CFG_W'(3));
    send_chars("QUJD");
    send_chars("QQ==");
    send_char(8'h2A);
    send_char(8'h41);
    send_eot();

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin strict_sel = 1'b0; cap_sel = CAP_MAX; end
        1: begin strict_sel = 1'b1; cap_sel = CAP_MAX; end
        2: begin strict_sel = 1'b0; cap_sel = '0; end
        3: begin strict_sel = 1'b1; cap_sel = CFG_W'($urandom_range(1, 30)); end
        4: begin strict_sel = 1'b0; cap_sel = CAP_MAX; end
        5: begin strict_sel = 1'b0; cap_sel = CFG_W'(1); end
        6: begin
          strict_sel = 1'($urandom_range(0, 1));
          cap_sel    = CFG_W'($urandom_range(0, 40));
        end
        default: begin strict_sel = 1'b0; cap_sel = CAP_MAX; end
      endcase
      write_reg(REG_STRICT, CFG_W'(strict_sel));
      write_reg(REG_CAPACITY, cap_sel);
      tx_gaps = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      rx_gaps = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      if (ph == 1) hold_off = 1'b1;
      phase_start = sent_count;
      while (sent_count - phase_start < 36) send_text();
      // leave bytes counted so the next phase starts above its lower capacity
      if (ph == 4) begin
        send_eot();
        send_chars("TWFu");
      end
    end
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = rx_gaps ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        res_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (res_valid && !res_stall) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

@@ files.f @@
sv/b64d_pkg.sv
sv/b64d_core.sv
sv/b64d_queue.sv
sv/base64_stream_decoder.sv
tb/b64d_checker.sv
tb/tb_base64_stream_decoder.sv
